// File: hdl/drc_pkg.sv
// drc_pkg: widths, register map, reset values, shared types and helpers
// for the drive ramp and current limiter; no dependencies
`timescale 1ns / 1ps

package drc_pkg;

  // field widths
  localparam int CMD_W   = 16;
  localparam int MAG_W   = CMD_W + 1;
  localparam int VOLT_W  = 12;
  localparam int CUR_W   = 11;
  localparam int SUM_W   = 13;
  localparam int SPV_W   = 16;
  localparam int GS_W    = 15;
  localparam int LIM_W   = 13;
  localparam int BRN_W   = 12;

  // ramp step arithmetic
  localparam int STEP_SHIFT  = 7;
  localparam int STEP_PROD_W = SPV_W + VOLT_W;
  localparam int STEP_W      = STEP_PROD_W - STEP_SHIFT;
  localparam int WIDE_W      = STEP_W + 2;

  // scaling divider
  localparam int NUM_W          = MAG_W + LIM_W;
  localparam int DEN_W          = SUM_W;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS      = NUM_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  // register port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_STEP_PER_VOLT    = 2'd0;
  localparam logic [1:0] REG_GHOST_STEP       = 2'd1;
  localparam logic [1:0] REG_CURRENT_LIMIT    = 2'd2;
  localparam logic [1:0] REG_BROWNOUT_VOLTAGE = 2'd3;

  localparam logic [SPV_W-1:0] RST_STEP_PER_VOLT    = SPV_W'(64);
  localparam logic [GS_W-1:0]  RST_GHOST_STEP       = GS_W'(256);
  localparam logic [LIM_W-1:0] RST_CURRENT_LIMIT    = LIM_W'(800);
  localparam logic [BRN_W-1:0] RST_BROWNOUT_VOLTAGE = BRN_W'(1280);

  localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(2 ** (CMD_W - 1) - 1);
  localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(-(2 ** (CMD_W - 1)));

  typedef struct packed {
    logic [SPV_W-1:0] step_per_volt;
    logic [GS_W-1:0]  ghost_step;
    logic [LIM_W-1:0] current_limit;
    logic [BRN_W-1:0] brownout_voltage;
  } drc_cfg_t;

  typedef struct packed {
    logic start;
    logic enable;
    logic clear;
  } lane_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

  // clamp a wide signed value to the command range
  function automatic logic signed [CMD_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [CMD_W-1:0] r;
    if (v > SAT_HI) begin
      r = {1'b0, {(CMD_W - 1){1'b1}}};
    end else if (v < SAT_LO) begin
      r = {1'b1, {(CMD_W - 1){1'b0}}};
    end else begin
      r = v[CMD_W-1:0];
    end
    return r;
  endfunction

  // magnitude of a command, one bit wider so the most negative value fits
  function automatic logic [MAG_W-1:0] mag(input logic signed [CMD_W-1:0] v);
    logic [MAG_W-1:0] ext;
    ext = {v[CMD_W-1], v};
    return v[CMD_W-1] ? (~ext + MAG_W'(1)) : ext;
  endfunction

endpackage

// File: hdl/drive_ramp_current_limiter.sv
// drive_ramp_current_limiter: two lanes (left, right) plus an output merge
// limiting off skips ramp and scaling; with limiting on a beat takes zero,
// one or two scalings, each a radix-4 divider pass
// a new beat is taken the cycle after both lanes hand their result over
// rst is synchronous: registers reload defaults, previous and trail clear
`timescale 1ns / 1ps

module drive_ramp_current_limiter (
  input  logic                                clk,
  input  logic                                rst,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [drc_pkg::ADDR_W-1:0]          paddr,
  input  logic [drc_pkg::DATA_W-1:0]          pwdata,
  output logic [drc_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [drc_pkg::CMD_W-1:0]    left_command,
  input  logic signed [drc_pkg::CMD_W-1:0]    right_command,
  input  logic                                limit_enable,
  input  logic                                clear_history,
  input  logic [drc_pkg::VOLT_W-1:0]          supply_voltage,
  input  logic [drc_pkg::CUR_W-1:0]           left_current_a,
  input  logic [drc_pkg::CUR_W-1:0]           left_current_b,
  input  logic [drc_pkg::CUR_W-1:0]           left_current_c,
  input  logic [drc_pkg::CUR_W-1:0]           right_current_a,
  input  logic [drc_pkg::CUR_W-1:0]           right_current_b,
  input  logic [drc_pkg::CUR_W-1:0]           right_current_c,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [drc_pkg::CMD_W-1:0]    left_drive,
  output logic signed [drc_pkg::CMD_W-1:0]    right_drive
);

  drc_pkg::drc_cfg_t                 cfg;
  drc_pkg::lane_req_t                req;
  drc_pkg::lane_stat_t               lstat;
  drc_pkg::lane_stat_t               rstat;
  logic signed [drc_pkg::CMD_W-1:0]  left_result;
  logic signed [drc_pkg::CMD_W-1:0]  right_result;
  logic                              load_out;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_per_volt    <= drc_pkg::RST_STEP_PER_VOLT;
      cfg.ghost_step       <= drc_pkg::RST_GHOST_STEP;
      cfg.current_limit    <= drc_pkg::RST_CURRENT_LIMIT;
      cfg.brownout_voltage <= drc_pkg::RST_BROWNOUT_VOLTAGE;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        drc_pkg::REG_STEP_PER_VOLT:
          cfg.step_per_volt <= pwdata[drc_pkg::SPV_W-1:0];
        drc_pkg::REG_GHOST_STEP:
          cfg.ghost_step <= pwdata[drc_pkg::GS_W-1:0];
        drc_pkg::REG_CURRENT_LIMIT:
          cfg.current_limit <= pwdata[drc_pkg::LIM_W-1:0];
        drc_pkg::REG_BROWNOUT_VOLTAGE:
          cfg.brownout_voltage <= pwdata[drc_pkg::BRN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      drc_pkg::REG_STEP_PER_VOLT:    prdata = drc_pkg::DATA_W'(cfg.step_per_volt);
      drc_pkg::REG_GHOST_STEP:       prdata = drc_pkg::DATA_W'(cfg.ghost_step);
      drc_pkg::REG_CURRENT_LIMIT:    prdata = drc_pkg::DATA_W'(cfg.current_limit);
      drc_pkg::REG_BROWNOUT_VOLTAGE: prdata = drc_pkg::DATA_W'(cfg.brownout_voltage);
      default:                       prdata = '0;
    endcase
  end

  // input beat goes to both lanes at once
  assign in_stall   = lstat.busy | rstat.busy;
  assign req.start  = in_valid & ~in_stall;
  assign req.enable = limit_enable;
  assign req.clear  = clear_history;

  drc_lane u_left (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .req            (req),
    .command        (left_command),
    .supply_voltage (supply_voltage),
    .current_a      (left_current_a),
    .current_b      (left_current_b),
    .current_c      (left_current_c),
    .ack            (load_out),
    .result         (left_result),
    .stat           (lstat)
  );

  drc_lane u_right (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .req            (req),
    .command        (right_command),
    .supply_voltage (supply_voltage),
    .current_a      (right_current_a),
    .current_b      (right_current_b),
    .current_c      (right_current_c),
    .ack            (load_out),
    .result         (right_result),
    .stat           (rstat)
  );

  // merge: both lanes finished and output register free
  assign load_out = lstat.done & rstat.done & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      left_drive  <= left_result;
      right_drive <= right_result;
    end
  end

  // an accepted beat keeps the lanes busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("lanes not busy after input beat");

  // handing the result over frees both lanes
  a_ack_idle: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (!lstat.busy && !rstat.busy))
    else $error("lane still busy after result handover");

  // a fresh output beat only comes from two finished lanes
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(lstat.done && rstat.done))
    else $error("output beat without finished lanes");

endmodule

// File: hdl/drc_div.sv
// drc_div: unsigned restoring divider, two quotient bits per cycle
// depends on drc_pkg for operand widths and step count
`timescale 1ns / 1ps

module drc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [drc_pkg::NUM_W-1:0]   dividend,
  input  logic [drc_pkg::DEN_W-1:0]   divisor,
  output logic                        done,
  output logic [drc_pkg::NUM_W-1:0]   quotient
);

  logic                           busy;
  logic [drc_pkg::DIV_CNT_W-1:0]  cnt;
  logic [drc_pkg::DEN_W-1:0]      den;
  logic [drc_pkg::DEN_W-1:0]      rem;
  logic [drc_pkg::NUM_W-1:0]      num;
  logic [drc_pkg::DEN_W-1:0]      rem_next;
  logic [drc_pkg::NUM_W-1:0]      num_next;

  // two shift-subtract steps; num shifts dividend out and quotient in
  always_comb begin
    logic [drc_pkg::DEN_W:0] trial;
    logic [drc_pkg::DEN_W:0] diff;
    logic                    qbit;
    rem_next = rem;
    num_next = num;
    for (int i = 0; i < drc_pkg::DIV_RADIX_BITS; i++) begin
      trial = {rem_next, num_next[drc_pkg::NUM_W-1]};
      diff  = trial - {1'b0, den};
      qbit  = (trial >= {1'b0, den});
      rem_next = qbit ? diff[drc_pkg::DEN_W-1:0] : trial[drc_pkg::DEN_W-1:0];
      num_next = {num_next[drc_pkg::NUM_W-2:0], qbit};
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + drc_pkg::DIV_CNT_W'(1);
        if (cnt == drc_pkg::DIV_CNT_W'(drc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign quotient = num;

endmodule

// File: hdl/drc_lane.sv
// drc_lane: one side of the limiter; ramp limit, trail decay, current and
// brownout scaling; depends on drc_pkg and drc_div
`timescale 1ns / 1ps

module drc_lane (
  input  logic                               clk,
  input  logic                               rst,
  input  drc_pkg::drc_cfg_t                  cfg,
  input  drc_pkg::lane_req_t                 req,
  input  logic signed [drc_pkg::CMD_W-1:0]   command,
  input  logic [drc_pkg::VOLT_W-1:0]         supply_voltage,
  input  logic [drc_pkg::CUR_W-1:0]          current_a,
  input  logic [drc_pkg::CUR_W-1:0]          current_b,
  input  logic [drc_pkg::CUR_W-1:0]          current_c,
  input  logic                               ack,
  output logic signed [drc_pkg::CMD_W-1:0]   result,
  output drc_pkg::lane_stat_t                stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_RAMP,
    S_MUL,
    S_DIV,
    S_DONE
  } lane_state_t;

  lane_state_t                        state;
  logic signed [drc_pkg::CMD_W-1:0]   cmd;
  logic signed [drc_pkg::CMD_W-1:0]   prev;
  logic signed [drc_pkg::CMD_W-1:0]   trail;
  logic [drc_pkg::STEP_W-1:0]         step;
  logic [drc_pkg::VOLT_W-1:0]         volt;
  logic [drc_pkg::SUM_W-1:0]          total;
  logic                               scale_brn;
  logic                               neg;

  logic [drc_pkg::STEP_PROD_W-1:0]    step_prod;
  logic signed [drc_pkg::CMD_W-1:0]   ramp_next;
  logic signed [drc_pkg::CMD_W-1:0]   trail_next;
  logic                               over_current;
  logic                               brownout;
  logic [drc_pkg::NUM_W-1:0]          scale_prod;
  logic [drc_pkg::DEN_W-1:0]          divisor;
  logic                               div_start;
  logic                               div_done;
  logic [drc_pkg::NUM_W-1:0]          quotient;
  logic signed [drc_pkg::CMD_W-1:0]   scaled;

  // ramp step proportional to supply
  assign step_prod = {{drc_pkg::VOLT_W{1'b0}}, cfg.step_per_volt}
                   * {{drc_pkg::SPV_W{1'b0}}, volt};

  // ramp limit and trail decay, both from the old previous output
  always_comb begin
    logic signed [drc_pkg::WIDE_W-1:0] cw, pw, tw, sw, gw, dw, base, tn;
    cw = drc_pkg::WIDE_W'(cmd);
    pw = drc_pkg::WIDE_W'(prev);
    tw = drc_pkg::WIDE_W'(trail);
    sw = $signed({2'b00, step});
    gw = $signed({{(drc_pkg::WIDE_W - drc_pkg::GS_W){1'b0}}, cfg.ghost_step});
    dw = $signed({{(drc_pkg::WIDE_W - drc_pkg::MAG_W){1'b0}}, drc_pkg::mag(cmd)})
       - $signed({{(drc_pkg::WIDE_W - drc_pkg::MAG_W){1'b0}}, drc_pkg::mag(prev)});
    if (pw > cw) begin
      base = (pw < 0 && tw > 0) ? tw : pw;
      base = base - sw;
    end else begin
      base = (pw > 0 && tw < 0) ? tw : pw;
      base = base + sw;
    end
    ramp_next = (dw > sw) ? drc_pkg::sat16(base) : cmd;
    if (tw > pw) begin
      tn = tw - gw;
      if (tn > pw) tn = pw;
    end else if (tw < pw) begin
      tn = tw + gw;
      if (tn < pw) tn = pw;
    end else begin
      tn = tw;
    end
    trail_next = drc_pkg::sat16(tn);
  end

  assign over_current = (total > cfg.current_limit);
  assign brownout     = (volt < cfg.brownout_voltage);

  // scaling multiply feeds the divider's input register
  assign scale_prod = drc_pkg::NUM_W'(drc_pkg::mag(cmd))
                    * (scale_brn ? drc_pkg::NUM_W'(volt)
                                 : drc_pkg::NUM_W'(cfg.current_limit));
  assign divisor    = scale_brn ? drc_pkg::DEN_W'(cfg.brownout_voltage) : total;
  assign div_start  = (state == S_MUL);

  drc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scale_prod),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // quotient magnitude never exceeds the input magnitude
  always_comb begin
    logic [drc_pkg::MAG_W-1:0] q;
    q = quotient[drc_pkg::MAG_W-1:0];
    q = neg ? (~q + drc_pkg::MAG_W'(1)) : q;
    scaled = q[drc_pkg::CMD_W-1:0];
  end

  // sequencer and lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prev      <= '0;
      trail     <= '0;
      scale_brn <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            cmd   <= command;
            volt  <= supply_voltage;
            total <= drc_pkg::SUM_W'(current_a) + drc_pkg::SUM_W'(current_b)
                   + drc_pkg::SUM_W'(current_c);
            if (req.clear) prev <= '0;
            state <= req.enable ? S_STEP : S_DONE;
          end
        end
        S_STEP: begin
          step  <= step_prod[drc_pkg::STEP_PROD_W-1:drc_pkg::STEP_SHIFT];
          state <= S_RAMP;
        end
        S_RAMP: begin
          cmd   <= ramp_next;
          trail <= trail_next;
          if (over_current) begin
            scale_brn <= 1'b0;
            state     <= S_MUL;
          end else if (brownout) begin
            scale_brn <= 1'b1;
            state     <= S_MUL;
          end else begin
            prev  <= ramp_next;
            state <= S_DONE;
          end
        end
        S_MUL: begin
          neg   <= cmd[drc_pkg::CMD_W-1];
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            cmd <= scaled;
            if (!scale_brn && brownout) begin
              scale_brn <= 1'b1;
              state     <= S_MUL;
            end else begin
              prev  <= scaled;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (ack) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result    = cmd;
  assign stat.busy = (state != S_IDLE);
  assign stat.done = (state == S_DONE);

endmodule
